FILE: hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error("%m failed");
`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error("%m failed");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

FILE: hdl/spse_pkg.sv
// Types and constants of the symmetric product square engine.
package spse_pkg;

  localparam int MAX_DIM_DEFAULT = 64;
  localparam int VALUE_W = 50;
  localparam int SIZE_W = 7;
  localparam int COORD_W = 6;
  localparam int SUM_BASE_W = 17;
  localparam logic [SIZE_W-1:0] MATRIX_SIZE_RESET = 7'd64;
  localparam logic [1:0] DRAIN_LAST = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_COMPUTE = 2'd1,
    OP_READ    = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DRAIN_SUM,
    ST_SQUARE,
    ST_DRAIN_SQUARE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic issue;
    logic square;
    logic first;
    logic last;
    logic load;
    logic read;
    logic read_ok;
    logic read_hit;
    logic done;
  } ctl_t;

endpackage

FILE: hdl/spse_ctrl.sv
// Controller: request decode, size register and compute sequencer.
module spse_ctrl #(
  parameter int MAX_DIM = spse_pkg::MAX_DIM_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           operation,
  input  logic [spse_pkg::COORD_W-1:0]         row,
  input  logic [spse_pkg::COORD_W-1:0]         col,
  input  logic                                 matrix_size_we,
  input  logic [spse_pkg::SIZE_W-1:0]          matrix_size_data,
  output spse_pkg::ctl_t                       ctl,
  output logic [2*$clog2(MAX_DIM)-1:0]         rd_addr0,
  output logic [2*$clog2(MAX_DIM)-1:0]         rd_addr1,
  output logic [2*$clog2(MAX_DIM)-1:0]         wr_addr,
  output logic [2*$clog2(MAX_DIM)-1:0]         host_addr
);
  import spse_pkg::*;

  localparam int IDX_W = $clog2(MAX_DIM);
  localparam int NW = $clog2(MAX_DIM + 1);
  localparam int CW = NW + COORD_W;

  state_t state, state_next;
  logic [SIZE_W-1:0] matrix_size;
  logic [NW-1:0] n, last_n, last_n_next;
  logic [IDX_W-1:0] i, j, k, i_next, j_next, k_next, nm1;
  logic [1:0] drain, drain_next;
  logic accept, in_dim, in_n, read_hit;
  logic k_end, j_end, i_end;
  op_t op;

  assign op = op_t'(operation);
  assign accept = start && !busy;
  assign busy = (state != ST_IDLE);

  always_comb begin
    if (matrix_size == '0) begin
      n = NW'(1);
    end else if (int'(matrix_size) > MAX_DIM) begin
      n = NW'(MAX_DIM);
    end else begin
      n = NW'(matrix_size);
    end
  end

  assign in_dim = (int'(row) < MAX_DIM) && (int'(col) < MAX_DIM);
  assign in_n = (CW'(row) < CW'(n)) && (CW'(col) < CW'(n));
  // lower triangle and cells beyond the last compute read as zero
  assign read_hit = in_n && (row <= col) && (CW'(row) < CW'(last_n))
                    && (CW'(col) < CW'(last_n));
  assign host_addr = {IDX_W'(row), IDX_W'(col)};

  assign nm1 = IDX_W'(last_n - NW'(1));
  assign k_end = (state == ST_SUM) ? (k == nm1) : (k == j);
  assign j_end = (j == nm1);
  assign i_end = (i == nm1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      matrix_size <= MATRIX_SIZE_RESET;
      last_n <= '0;
      i <= '0;
      j <= '0;
      k <= '0;
      drain <= '0;
    end else begin
      state <= state_next;
      if (matrix_size_we) begin
        matrix_size <= matrix_size_data;
      end
      last_n <= last_n_next;
      i <= i_next;
      j <= j_next;
      k <= k_next;
      drain <= drain_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && op == OP_COMPUTE) state_next = ST_SUM;
      end
      ST_SUM: begin
        if (k_end && j_end && i_end) state_next = ST_DRAIN_SUM;
      end
      ST_DRAIN_SUM: begin
        if (drain == DRAIN_LAST) state_next = ST_SQUARE;
      end
      ST_SQUARE: begin
        if (k_end && j_end && i_end) state_next = ST_DRAIN_SQUARE;
      end
      ST_DRAIN_SQUARE: begin
        if (drain == DRAIN_LAST) state_next = ST_DONE;
      end
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // loop counters: sum walks k over 0..n-1, square walks k over i..j
  always_comb begin
    i_next = i;
    j_next = j;
    k_next = k;
    drain_next = '0;
    last_n_next = last_n;
    case (state)
      ST_IDLE: begin
        i_next = '0;
        j_next = '0;
        k_next = '0;
        if (accept && op == OP_COMPUTE) last_n_next = n;
      end
      ST_SUM: begin
        if (k_end) begin
          k_next = '0;
          if (j_end) begin
            i_next = i + IDX_W'(1);
            j_next = i + IDX_W'(1);
          end else begin
            j_next = j + IDX_W'(1);
          end
        end else begin
          k_next = k + IDX_W'(1);
        end
      end
      ST_SQUARE: begin
        if (k_end) begin
          if (j_end) begin
            i_next = i + IDX_W'(1);
            j_next = i + IDX_W'(1);
            k_next = i + IDX_W'(1);
          end else begin
            j_next = j + IDX_W'(1);
            k_next = i;
          end
        end else begin
          k_next = k + IDX_W'(1);
        end
      end
      ST_DRAIN_SUM, ST_DRAIN_SQUARE: begin
        i_next = '0;
        j_next = '0;
        k_next = '0;
        drain_next = (drain == DRAIN_LAST) ? 2'd0 : drain + 2'd1;
      end
      default: begin
        i_next = '0;
        j_next = '0;
        k_next = '0;
      end
    endcase
  end

  always_comb begin
    ctl = '0;
    ctl.issue = (state == ST_SUM) || (state == ST_SQUARE);
    ctl.square = (state == ST_SQUARE);
    ctl.first = (state == ST_SUM) ? (k == '0) : (k == i);
    ctl.last = k_end;
    ctl.load = accept && (op == OP_LOAD) && in_dim;
    ctl.read = accept && (op == OP_READ);
    ctl.read_ok = in_n;
    ctl.read_hit = read_hit;
    ctl.done = (state == ST_DONE);
    rd_addr0 = (state == ST_SUM) ? {k, i} : {i, k};
    rd_addr1 = {k, j};
    wr_addr = {i, j};
  end

endmodule

FILE: hdl/spse_datapath.sv
// Datapath: element stores, multiply-accumulate pipeline and result register.
module spse_datapath #(
  parameter int MAX_DIM = spse_pkg::MAX_DIM_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  spse_pkg::ctl_t                       ctl,
  input  logic [2*$clog2(MAX_DIM)-1:0]         rd_addr0,
  input  logic [2*$clog2(MAX_DIM)-1:0]         rd_addr1,
  input  logic [2*$clog2(MAX_DIM)-1:0]         wr_addr,
  input  logic [2*$clog2(MAX_DIM)-1:0]         host_addr,
  input  logic signed [7:0]                    a_value,
  input  logic signed [7:0]                    b_value,
  output logic                                 strobe,
  output logic signed [spse_pkg::VALUE_W-1:0]  value,
  output logic                                 ok
);
  import spse_pkg::*;

  localparam int AW = 2 * $clog2(MAX_DIM);
  localparam int DEPTH = 1 << AW;
  localparam int SUM_W = SUM_BASE_W + $clog2(MAX_DIM);

  logic signed [7:0] a_mem [DEPTH];
  logic signed [7:0] b_mem [DEPTH];
  logic signed [SUM_W-1:0] sum_mem [DEPTH];
  logic signed [VALUE_W-1:0] sq_mem [DEPTH];

  logic signed [7:0] a0, a1, b0, b1;
  logic signed [SUM_W-1:0] s0, s1;
  logic signed [VALUE_W-1:0] sq_rd;
  logic v1, sq1, first1, last1;
  logic [AW-1:0] waddr1, waddr2;
  logic v2, sq2, first2, last2;
  logic signed [VALUE_W-1:0] p0, p1, acc, acc_next, sum2;
  logic signed [15:0] ab0, ab1;
  logic signed [2*SUM_W-1:0] s_prod;
  logic zero_out;
  logic wr_sum, wr_sq;

  assign wr_sum = v2 && last2 && !sq2;
  assign wr_sq = v2 && last2 && sq2;

  always_ff @(posedge clk) begin
    if (ctl.load) a_mem[host_addr] <= a_value;
    a0 <= a_mem[rd_addr0];
    a1 <= a_mem[rd_addr1];
  end

  always_ff @(posedge clk) begin
    if (ctl.load) b_mem[host_addr] <= b_value;
    b0 <= b_mem[rd_addr0];
    b1 <= b_mem[rd_addr1];
  end

  always_ff @(posedge clk) begin
    if (wr_sum) sum_mem[waddr2] <= SUM_W'(acc_next);
    s0 <= sum_mem[rd_addr0];
    s1 <= sum_mem[rd_addr1];
  end

  always_ff @(posedge clk) begin
    if (wr_sq) sq_mem[waddr2] <= acc_next;
    sq_rd <= sq_mem[host_addr];
  end

  assign ab0 = a0 * b1;
  assign ab1 = b0 * a1;
  assign s_prod = s0 * s1;
  assign sum2 = p0 + p1;
  // restart the sum on the first term of each output cell
  assign acc_next = first2 ? sum2 : acc + sum2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      strobe <= 1'b0;
    end else begin
      v1 <= ctl.issue;
      v2 <= v1;
      strobe <= ctl.read || ctl.done;
    end
  end

  always_ff @(posedge clk) begin
    sq1 <= ctl.square;
    first1 <= ctl.first;
    last1 <= ctl.last;
    waddr1 <= wr_addr;
    sq2 <= sq1;
    first2 <= first1;
    last2 <= last1;
    waddr2 <= waddr1;
    p0 <= sq1 ? VALUE_W'(s_prod) : VALUE_W'(ab0);
    p1 <= sq1 ? '0 : VALUE_W'(ab1);
    if (v2) acc <= acc_next;
    ok <= (ctl.read && ctl.read_ok) || ctl.done;
    zero_out <= !(ctl.read && ctl.read_hit);
  end

  assign value = zero_out ? '0 : sq_rd;

endmodule

FILE: hdl/symmetric_product_square_engine.sv
// Top level of the symmetric product square engine.
// Load and read requests are taken one per cycle while busy is low; a read's result shows
// on strobe in the cycle after it is accepted, and loads give no result. A compute request
// holds busy while it runs, and its result shows on strobe in the first cycle that busy
// is low: one multiply-accumulate pipeline handles one term per cycle, first over
// S = A^T*B + B^T*A and then over C = U*U, U the upper triangle of S, with a drain state
// after each pass. Results cannot be held off by the receiver.
module symmetric_product_square_engine #(
  parameter int MAX_DIM = spse_pkg::MAX_DIM_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           operation,
  input  logic [spse_pkg::COORD_W-1:0]         row,
  input  logic [spse_pkg::COORD_W-1:0]         col,
  input  logic signed [7:0]                    a_value,
  input  logic signed [7:0]                    b_value,
  input  logic                                 matrix_size_we,
  input  logic [spse_pkg::SIZE_W-1:0]          matrix_size_data,
  output logic                                 strobe,
  output logic signed [spse_pkg::VALUE_W-1:0]  value,
  output logic                                 ok
);
  import spse_pkg::*;

  `include "assert_macros.svh"

  localparam int AW = 2 * $clog2(MAX_DIM);

  ctl_t ctl;
  logic [AW-1:0] rd_addr0, rd_addr1, wr_addr, host_addr;

  spse_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .operation(operation),
    .row(row),
    .col(col),
    .matrix_size_we(matrix_size_we),
    .matrix_size_data(matrix_size_data),
    .ctl(ctl),
    .rd_addr0(rd_addr0),
    .rd_addr1(rd_addr1),
    .wr_addr(wr_addr),
    .host_addr(host_addr)
  );

  spse_datapath #(.MAX_DIM(MAX_DIM)) u_datapath (
    .clk(clk),
    .rst(rst),
    .ctl(ctl),
    .rd_addr0(rd_addr0),
    .rd_addr1(rd_addr1),
    .wr_addr(wr_addr),
    .host_addr(host_addr),
    .a_value(a_value),
    .b_value(b_value),
    .strobe(strobe),
    .value(value),
    .ok(ok)
  );

  `ASSERT_NEVER(a_no_result_while_busy, clk, rst, busy && strobe)
  `ASSERT_PROP(a_reject_is_zero, clk, rst, (strobe && !ok) |-> (value == '0))
  `ASSERT_PROP(a_compute_goes_busy, clk, rst, (start && !busy && operation == OP_COMPUTE) |=> busy)

endmodule
